/* sv/hew_pkg.sv */
// Shared constants for the heading error block: arctangent table and angle formats.
// No dependencies; used by the cell, pre-rotation, wrap and top modules.
package hew_pkg;

  // Angles are degrees with 16 fraction bits.
  localparam int ANGLE_W    = 26;
  localparam int FRAC_BITS  = 16;
  localparam int GUARD_BITS = 8;
  localparam int TABLE_LEN  = 24;
  localparam int OUT_W      = 16;

  localparam int DEG_90   = 90 << FRAC_BITS;
  localparam int DEG_HALF = 180 << FRAC_BITS;
  localparam int DEG_FULL = 360 << FRAC_BITS;

  // Q16 result down to Q7, half rounds up.
  localparam int ROUND_SHIFT = FRAC_BITS - 7;
  localparam int ROUND_BIAS  = 1 << (ROUND_SHIFT - 1);

  // atan(2^-i) in degrees, Q16, rounded to nearest.
  localparam logic [21:0] ATAN_Q16 [TABLE_LEN] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
    22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
  };

endpackage

/* sv/hew_prerot.sv */
// Input stage for one vector: sign extension, y flip, guard scaling and
// the left half-plane quarter turn. Depends on hew_pkg.
module hew_prerot #(
  parameter int CW = 16,
  parameter int XW = 28
) (
  input  logic                                clk,
  input  logic                                ena,
  input  logic        [CW-1:0]                raw_x,
  input  logic        [CW-1:0]                raw_y,
  output logic signed [XW-1:0]                x,
  output logic signed [XW-1:0]                y,
  output logic signed [hew_pkg::ANGLE_W-1:0]  acc,
  output logic                                zero
);

  localparam int AW = hew_pkg::ANGLE_W;
  localparam int GB = hew_pkg::GUARD_BITS;
  localparam logic signed [AW-1:0] QTR = AW'(hew_pkg::DEG_90);

  logic signed [XW-1:0] xe, ye, yn;
  logic signed [XW-1:0] x_next, y_next;
  logic signed [AW-1:0] acc_next;

  assign xe = {{(XW-CW-GB){raw_x[CW-1]}}, raw_x, {GB{1'b0}}};
  assign ye = {{(XW-CW-GB){raw_y[CW-1]}}, raw_y, {GB{1'b0}}};
  assign yn = -ye;

  always_comb begin
    x_next   = xe;
    y_next   = yn;
    acc_next = '0;
    if (xe < 0) begin
      if (yn >= 0) begin
        x_next   = yn;
        y_next   = -xe;
        acc_next = QTR;
      end else begin
        x_next   = -yn;
        y_next   = xe;
        acc_next = -QTR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ena) begin
      x    <= x_next;
      y    <= y_next;
      acc  <= acc_next;
      zero <= (raw_x == '0) && (raw_y == '0);
    end
  end

endmodule

/* sv/hew_cell.sv */
// One CORDIC vectoring micro-rotation with its output register.
// Depends on hew_pkg for the arctangent table.
module hew_cell #(
  parameter int XW    = 28,
  parameter int STAGE = 0
) (
  input  logic                                clk,
  input  logic                                ena,
  input  logic signed [XW-1:0]                x_in,
  input  logic signed [XW-1:0]                y_in,
  input  logic signed [hew_pkg::ANGLE_W-1:0]  acc_in,
  input  logic                                zero_in,
  output logic signed [XW-1:0]                x_out,
  output logic signed [XW-1:0]                y_out,
  output logic signed [hew_pkg::ANGLE_W-1:0]  acc_out,
  output logic                                zero_out
);

  localparam int AW = hew_pkg::ANGLE_W;
  localparam logic signed [AW-1:0] ANG = AW'(hew_pkg::ATAN_Q16[STAGE]);

  logic signed [XW-1:0] xs, ys;

  assign xs = x_in >>> STAGE;
  assign ys = y_in >>> STAGE;

  always_ff @(posedge clk) begin
    if (ena) begin
      // residual of exactly zero rotates the negative way
      if (y_in > 0) begin
        x_out   <= x_in + ys;
        y_out   <= y_in - xs;
        acc_out <= acc_in + ANG;
      end else begin
        x_out   <= x_in - ys;
        y_out   <= y_in + xs;
        acc_out <= acc_in - ANG;
      end
      zero_out <= zero_in;
    end
  end

endmodule

/* sv/hew_wrap.sv */
// Output stage: heading difference, wrap into +-180 degrees, round to Q7.
// Depends on hew_pkg.
module hew_wrap (
  input  logic                                clk,
  input  logic                                ena,
  input  logic signed [hew_pkg::ANGLE_W-1:0]  cur_acc,
  input  logic                                cur_zero,
  input  logic signed [hew_pkg::ANGLE_W-1:0]  des_acc,
  input  logic                                des_zero,
  output logic signed [hew_pkg::OUT_W-1:0]    heading_error
);

  localparam int AW = hew_pkg::ANGLE_W;
  localparam int DW = AW + 1;
  localparam logic signed [DW-1:0] HALF = DW'(hew_pkg::DEG_HALF);
  localparam logic signed [DW-1:0] FULL = DW'(hew_pkg::DEG_FULL);
  localparam logic signed [DW-1:0] BIAS = DW'(hew_pkg::ROUND_BIAS);

  logic signed [DW-1:0] ca, da, diff, wrapped, biased, shifted;

  assign ca   = cur_zero ? '0 : {cur_acc[AW-1], cur_acc};
  assign da   = des_zero ? '0 : {des_acc[AW-1], des_acc};
  assign diff = da - ca;

  always_comb begin
    if (diff > HALF) begin
      wrapped = diff - FULL;
    end else if (diff < -HALF) begin
      wrapped = diff + FULL;
    end else begin
      wrapped = diff;
    end
  end

  assign biased  = wrapped + BIAS;
  assign shifted = biased >>> hew_pkg::ROUND_SHIFT;

  always_ff @(posedge clk) begin
    if (ena) begin
      heading_error <= shifted[hew_pkg::OUT_W-1:0];
    end
  end

endmodule

/* sv/heading_error_from_vectors.sv */
// Heading error between a current and a desired direction vector, CORDIC based.
// Pipeline: input stage, one cell per micro-rotation, wrap stage.
// Throughput: one vector pair per cycle; a full stage holds only while its successor holds.
// Ready ripples back from the output: a stage is ready when empty or its successor is ready.
// Reset (rst, synchronous) clears the per-stage valid bits only; payload is not reset.
// Depends on hew_pkg, hew_prerot, hew_cell and hew_wrap.
module heading_error_from_vectors #(
  parameter int COORD_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // current_x, current_y, desired_x, desired_y (lowest first), zero padded to bytes
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // heading_error
  output logic [hew_pkg::OUT_W-1:0]              m_axis_tdata
);

  localparam int CW  = COORD_WIDTH;
  localparam int XW  = COORD_WIDTH + 12;
  localparam int AW  = hew_pkg::ANGLE_W;
  localparam int NST = (CORDIC_STAGES < hew_pkg::TABLE_LEN) ? CORDIC_STAGES
                                                            : hew_pkg::TABLE_LEN;
  localparam int NV  = NST + 2;   // input stage, cells, output stage

  logic [NV-1:0] vld;
  logic [NV-1:0] rdy;

  logic signed [XW-1:0] cx   [NST+1];
  logic signed [XW-1:0] cy   [NST+1];
  logic signed [AW-1:0] cacc [NST+1];
  logic                 cz   [NST+1];
  logic signed [XW-1:0] dx   [NST+1];
  logic signed [XW-1:0] dy   [NST+1];
  logic signed [AW-1:0] dacc [NST+1];
  logic                 dz   [NST+1];
  logic signed [hew_pkg::OUT_W-1:0] err;

  // ready ripples back from the output register
  always_comb begin
    rdy[NV-1] = !vld[NV-1] || m_axis_tready;
    for (int k = NV - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NV; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  hew_prerot #(.CW(CW), .XW(XW)) u_cur_pre (
    .clk   (clk),
    .ena   (rdy[0]),
    .raw_x (s_axis_tdata[CW-1:0]),
    .raw_y (s_axis_tdata[2*CW-1:CW]),
    .x     (cx[0]),
    .y     (cy[0]),
    .acc   (cacc[0]),
    .zero  (cz[0])
  );

  hew_prerot #(.CW(CW), .XW(XW)) u_des_pre (
    .clk   (clk),
    .ena   (rdy[0]),
    .raw_x (s_axis_tdata[3*CW-1:2*CW]),
    .raw_y (s_axis_tdata[4*CW-1:3*CW]),
    .x     (dx[0]),
    .y     (dy[0]),
    .acc   (dacc[0]),
    .zero  (dz[0])
  );

  for (genvar i = 0; i < NST; i++) begin : g_rot
    hew_cell #(.XW(XW), .STAGE(i)) u_cur_rot (
      .clk      (clk),
      .ena      (rdy[i+1]),
      .x_in     (cx[i]),
      .y_in     (cy[i]),
      .acc_in   (cacc[i]),
      .zero_in  (cz[i]),
      .x_out    (cx[i+1]),
      .y_out    (cy[i+1]),
      .acc_out  (cacc[i+1]),
      .zero_out (cz[i+1])
    );

    hew_cell #(.XW(XW), .STAGE(i)) u_des_rot (
      .clk      (clk),
      .ena      (rdy[i+1]),
      .x_in     (dx[i]),
      .y_in     (dy[i]),
      .acc_in   (dacc[i]),
      .zero_in  (dz[i]),
      .x_out    (dx[i+1]),
      .y_out    (dy[i+1]),
      .acc_out  (dacc[i+1]),
      .zero_out (dz[i+1])
    );
  end

  hew_wrap u_wrap (
    .clk           (clk),
    .ena           (rdy[NV-1]),
    .cur_acc       (cacc[NST]),
    .cur_zero      (cz[NST]),
    .des_acc       (dacc[NST]),
    .des_zero      (dz[NST]),
    .heading_error (err)
  );

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld[NV-1];
  assign m_axis_tdata  = err;

  // an empty output register means no stage can be blocked
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> vld[0])
    else $error("accepted request did not enter the pipeline");

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata) >= -16'sd23040 &&
                       $signed(m_axis_tdata) <= 16'sd23040))
    else $error("heading error outside +-180 degrees");

endmodule

/* bench/heading_error_from_vectors_test.sv */
// Self-checking bench for heading_error_from_vectors: drives vector-pair requests on the
// input stream, predicts each heading error with a bit-exact CORDIC model, checks outputs.
// Depends on the heading_error_from_vectors top level and its package.
module heading_error_from_vectors_test;

  localparam int COORD_W    = 16;
  localparam int STAGES     = 16;
  localparam int LATENCY    = STAGES + 2;
  localparam int STALL_MAX  = 4000;
  localparam int HOLD_LEN   = 150;
  localparam int TBL_LEN    = 24;
  localparam longint DEG_Q16 = 65536;

  // atan(2^-i) in degrees, Q16
  localparam longint ATAN_DEG [TBL_LEN] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // current_x, current_y, desired_x, desired_y (lowest first)
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // heading_error
  logic [15:0] m_axis_tdata;

  logic [15:0] expected_errors [$];
  int          src_idle_pct = 0;
  int          sink_idle_pct = 0;
  bit          hold_active = 1'b0;
  int          hold_cycles = 0;
  int          err_count = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          stall_cycles = 0;

  heading_error_from_vectors #(
    .COORD_WIDTH  (COORD_W),
    .CORDIC_STAGES(STAGES)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // heading of (x, y) with y axis down, degrees Q16
  function automatic longint vector_heading(input logic signed [15:0] vx,
                                            input logic signed [15:0] vy);
    longint x, y, acc, t, xs, ys;
    x = longint'(vx);
    y = -longint'(vy);
    acc = 0;
    if (x == 0 && y == 0) return 0;
    x = x * 256;
    y = y * 256;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; acc = 90 * DEG_Q16;
      end else begin
        x = -y; y = t; acc = -90 * DEG_Q16;
      end
    end
    for (int i = 0; i < STAGES && i < TBL_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      // zero residual takes the decreasing branch
      if (y > 0) begin
        x = x + ys; y = y - xs; acc = acc + ATAN_DEG[i];
      end else begin
        x = x - ys; y = y + xs; acc = acc - ATAN_DEG[i];
      end
    end
    return acc;
  endfunction

  function automatic logic [15:0] predict_heading_error(input logic [15:0] cx, cy, dx, dy);
    longint diff, q7;
    diff = vector_heading(dx, dy) - vector_heading(cx, cy);
    if (diff > 180 * DEG_Q16) diff = diff - 360 * DEG_Q16;
    else if (diff < -180 * DEG_Q16) diff = diff + 360 * DEG_Q16;
    q7 = (diff + 256) >>> 9;
    return q7[15:0];
  endfunction

  function automatic logic [15:0] rand_coord();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return 16'($urandom);
    if (pick < 75) return 16'($signed($urandom_range(16)) - 8);
    if (pick < 83) return 16'h0000;
    if (pick < 90) return ($urandom_range(1) != 0) ? 16'h7fff : 16'h8000;
    return 16'($signed($urandom_range(512)) - 256);
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got, exp_val);
    $display("mismatch %s: got %0d expected %0d (result %0d)",
             what, $signed(got), $signed(exp_val), results_seen);
    err_count++;
  endtask

  task automatic send_vectors(input logic [15:0] cx, cy, dx, dy);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dy, dx, cy, cx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_errors.push_back(predict_heading_error(cx, cy, dx, dy));
    items_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_errors.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) begin
      send_vectors(rand_coord(), rand_coord(), rand_coord(), rand_coord());
    end
    wait_drained();
  endtask

  task automatic test_directed();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    send_vectors(16'h0000, 16'h0000, 16'h0000, 16'h0000);  // both zero vectors
    send_vectors(16'h0000, 16'h0000, 16'h7fff, 16'h0000);  // zero current
    send_vectors(16'h7fff, 16'h0000, 16'h0000, 16'h0000);  // zero desired, zero residual
    send_vectors(16'h0000, 16'h0000, 16'h8000, 16'h0000);  // negative x axis, near +180
    send_vectors(16'h8000, 16'h0000, 16'h0000, 16'h0000);
    send_vectors(16'h0000, 16'h7fff, 16'h0000, 16'h8000);
    send_vectors(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_vectors(16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
    send_vectors(16'h8000, 16'h7fff, 16'h8000, 16'h8000);  // left half, both turns
    send_vectors(16'h8000, 16'hfc18, 16'h8000, 16'h03e8);  // wrap below -180
    send_vectors(16'h8000, 16'h03e8, 16'h8000, 16'hfc18);  // wrap above +180
    send_vectors(16'h0001, 16'h0000, 16'hffff, 16'h0000);
    send_vectors(16'h0000, 16'h0001, 16'h0000, 16'hffff);
    send_vectors(16'hffff, 16'hffff, 16'h0001, 16'h0001);
    send_vectors(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_vectors(16'hffff, 16'h0000, 16'h0001, 16'h0000);
    send_vectors(16'h0000, 16'h8000, 16'h0000, 16'h7fff);
    send_vectors(16'h5555, 16'haaaa, 16'haaaa, 16'h5555);
    send_vectors(16'h8000, 16'h0001, 16'h8000, 16'hffff);  // just either side of -x axis
    wait_drained();
  endtask

  task automatic test_random_slow_sink();
    src_idle_pct = 7;
    sink_idle_pct = 69;
    run_random(360);
  endtask

  task automatic test_random_slow_source();
    src_idle_pct = 69;
    sink_idle_pct = 7;
    run_random(360);
  endtask

  task automatic test_random_full_rate();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    run_random(360);
  endtask

  // sink stops for a long stretch while requests keep coming, pipeline must fill and stall
  task automatic test_backpressure();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    hold_active = 1'b1;
    for (int n = 0; n < 64; n++) begin
      send_vectors(rand_coord(), rand_coord(), rand_coord(), rand_coord());
    end
    hold_active = 1'b0;
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (!hold_active) begin
      hold_cycles <= 0;
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end else if (hold_cycles < HOLD_LEN) begin
      hold_cycles <= hold_cycles + 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    logic [15:0] exp_val;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_errors.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, 16'h0000);
      end else begin
        exp_val = expected_errors.pop_front();
        if (m_axis_tdata !== exp_val) report_mismatch("heading_error", m_axis_tdata, exp_val);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("timeout after %0d cycles with no transfer", stall_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_slow_sink();
    test_random_slow_source();
    test_random_full_rate();
    test_backpressure();
    if (expected_errors.size() != 0) begin
      report_mismatch("missing results", 16'h0000, 16'(expected_errors.size()));
    end
    $display("covered directed edge vectors, three idle mixes and a long sink stall");
    $display("%0d requests sent, %0d results checked, %0d mismatches",
             items_sent, results_seen, err_count);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
